[rtl/ipd_pkg.sv]
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types and constants for the instruction predecoder.
// ----------------------------------------------------------------------------
package ipd_pkg;

  // Operation codes of the decode result
  typedef enum logic [4:0] {
    OP_ADDB = 5'd0,  OP_ADD  = 5'd1,  OP_SUBB = 5'd2,  OP_SUB  = 5'd3,
    OP_ORB  = 5'd4,  OP_OR   = 5'd5,  OP_ANDB = 5'd6,  OP_AND  = 5'd7,
    OP_XORB = 5'd8,  OP_XOR  = 5'd9,  OP_CPB  = 5'd10, OP_CP   = 5'd11,
    OP_LDB  = 5'd12, OP_LD   = 5'd13, OP_JR   = 5'd14, OP_PUSH = 5'd15,
    OP_POP  = 5'd16, OP_CALR = 5'd17, OP_CALL = 5'd18, OP_JP   = 5'd19,
    OP_RET  = 5'd20, OP_EI   = 5'd21, OP_DI   = 5'd22, OP_IN   = 5'd23,
    OP_INB  = 5'd24, OP_OUT  = 5'd25, OP_OUTB = 5'd26, OP_NOP  = 5'd27,
    OP_HALT = 5'd28, OP_IRET = 5'd29, OP_DW   = 5'd30
  } op_e;

  // Operand forms
  typedef enum logic [3:0] {
    FORM_NONE      = 4'd0,
    FORM_REG_REG   = 4'd1,
    FORM_REG_IMM   = 4'd2,
    FORM_REG_IND   = 4'd3,
    FORM_IND_REG   = 4'd4,
    FORM_REG_ADDR  = 4'd5,
    FORM_ADDR_REG  = 4'd6,
    FORM_TARGET    = 4'd7,
    FORM_IND       = 4'd8,
    FORM_COND      = 4'd9,
    FORM_MASK      = 4'd10,
    FORM_REG_PORT  = 4'd11,
    FORM_PORT_REG  = 4'd12,
    FORM_DATA      = 4'd13
  } form_e;

  // Fixed instruction words
  localparam logic [15:0] NOP_WORD  = 16'h8D07;
  localparam logic [15:0] HALT_WORD = 16'h7A00;
  localparam logic [15:0] IRET_WORD = 16'h7B00;
  localparam logic [3:0]  CC_ALWAYS = 4'h8;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  // Structured decode of one instruction
  typedef struct packed {
    op_e         op_code;
    form_e       operand_form;
    logic [3:0]  first_reg;
    logic [3:0]  second_reg;
    logic        byte_regs;
    logic        cond_shown;
    logic [3:0]  cond_code;
    logic [15:0] value;
    logic [1:0]  length_words;
  } dec_t;

endpackage

[rtl/ipd_decode.sv]
// ----------------------------------------------------------------------------
// ipd_decode
// Combinational decode of one instruction word pair, first match wins.
// ----------------------------------------------------------------------------
module ipd_decode
  import ipd_pkg::*;
(
  input  logic [15:0] instr_addr_i,
  input  logic [15:0] instr_word_i,
  input  logic [15:0] ext_word_i,
  output dec_t        dec_o
);

  logic [7:0]  hi;
  logic [7:0]  lo8;
  logic [3:0]  lo4;
  logic [3:0]  mid4;
  logic [15:0] jr_target;
  logic [15:0] calr_target;
  logic [3:0]  cc_raw;
  logic        cc_used;
  dec_t        d;

  assign hi   = instr_word_i[15:8];
  assign lo8  = instr_word_i[7:0];
  assign lo4  = instr_word_i[3:0];
  assign mid4 = instr_word_i[7:4];

  // Relative branch targets, both wrap at 16 bits
  assign jr_target   = instr_addr_i + 16'd2 + {{7{lo8[7]}}, lo8, 1'b0};
  assign calr_target = instr_addr_i + 16'd2 - {3'b000, instr_word_i[11:0], 1'b0};

  // Priority decode
  always_comb begin
    d              = '0;
    d.op_code      = OP_DW;
    d.operand_form = FORM_DATA;
    d.length_words = 2'd1;
    d.value        = instr_word_i;
    cc_used        = 1'b0;
    cc_raw         = 4'h0;
    if (hi >= 8'h80 && hi <= 8'h8B) begin
      d.op_code      = op_e'({1'b0, hi[3:0]});
      d.operand_form = FORM_REG_REG;
      d.first_reg    = lo4;
      d.second_reg   = mid4;
      d.byte_regs    = ~hi[0];
      d.value        = '0;
    end else if (hi == 8'hA0 || hi == 8'hA1) begin
      d.op_code      = hi[0] ? OP_LD : OP_LDB;
      d.operand_form = FORM_REG_REG;
      d.first_reg    = lo4;
      d.second_reg   = mid4;
      d.byte_regs    = ~hi[0];
      d.value        = '0;
    end else if (hi[7:4] == 4'hC) begin
      d.op_code      = OP_LDB;
      d.operand_form = FORM_REG_IMM;
      d.first_reg    = hi[3:0];
      d.byte_regs    = 1'b1;
      d.value        = {8'h00, lo8};
    end else if (hi == 8'h21 && mid4 == 4'h0) begin
      d.op_code      = OP_LD;
      d.operand_form = FORM_REG_IMM;
      d.first_reg    = lo4;
      d.value        = ext_word_i;
      d.length_words = 2'd2;
    end else if (hi[7:4] == 4'hE) begin
      d.op_code      = OP_JR;
      d.operand_form = FORM_TARGET;
      cc_used        = 1'b1;
      cc_raw         = hi[3:0];
      d.value        = jr_target;
    end else if (hi == 8'h20 || hi == 8'h21) begin
      d.op_code      = hi[0] ? OP_LD : OP_LDB;
      d.operand_form = FORM_REG_IND;
      d.first_reg    = lo4;
      d.second_reg   = mid4;
      d.byte_regs    = ~hi[0];
      d.value        = '0;
    end else if (hi == 8'h2E || hi == 8'h2F) begin
      d.op_code      = hi[0] ? OP_LD : OP_LDB;
      d.operand_form = FORM_IND_REG;
      d.first_reg    = mid4;
      d.second_reg   = lo4;
      d.byte_regs    = ~hi[0];
      d.value        = '0;
    end else if ((hi == 8'h70 || hi == 8'h71) && mid4 == 4'h0) begin
      d.op_code      = hi[0] ? OP_LD : OP_LDB;
      d.operand_form = FORM_REG_ADDR;
      d.first_reg    = lo4;
      d.byte_regs    = ~hi[0];
      d.value        = ext_word_i;
      d.length_words = 2'd2;
    end else if ((hi == 8'h78 || hi == 8'h79) && mid4 == 4'h0) begin
      d.op_code      = hi[0] ? OP_LD : OP_LDB;
      d.operand_form = FORM_ADDR_REG;
      d.second_reg   = lo4;
      d.byte_regs    = ~hi[0];
      d.value        = ext_word_i;
      d.length_words = 2'd2;
    end else if (hi == 8'h13) begin
      d.op_code      = OP_PUSH;
      d.operand_form = FORM_IND_REG;
      d.first_reg    = mid4;
      d.second_reg   = lo4;
      d.value        = '0;
    end else if (hi == 8'h17) begin
      d.op_code      = OP_POP;
      d.operand_form = FORM_REG_IND;
      d.first_reg    = lo4;
      d.second_reg   = mid4;
      d.value        = '0;
    end else if (hi[7:4] == 4'hD) begin
      d.op_code      = OP_CALR;
      d.operand_form = FORM_TARGET;
      d.value        = calr_target;
    end else if (hi == 8'h5F) begin
      d.op_code = OP_CALL;
      if (lo8 == 8'h00) begin
        d.operand_form = FORM_TARGET;
        d.value        = ext_word_i;
        d.length_words = 2'd2;
      end else begin
        // CALL @Rd, register in bits 7..4
        d.operand_form = FORM_IND;
        d.first_reg    = mid4;
        d.value        = '0;
      end
    end else if (hi == 8'h5E) begin
      d.op_code      = OP_JP;
      d.operand_form = FORM_TARGET;
      cc_used        = 1'b1;
      cc_raw         = lo4;
      d.value        = ext_word_i;
      d.length_words = 2'd2;
    end else if (hi == 8'h1E) begin
      d.op_code      = OP_JP;
      d.operand_form = FORM_IND;
      d.first_reg    = mid4;
      cc_used        = 1'b1;
      cc_raw         = lo4;
      d.value        = '0;
    end else if (hi == 8'h9E) begin
      d.op_code      = OP_RET;
      d.operand_form = (lo4 == CC_ALWAYS) ? FORM_NONE : FORM_COND;
      cc_used        = 1'b1;
      cc_raw         = lo4;
      d.value        = '0;
    end else if (hi == 8'h7C && lo8[7:3] == 5'd0) begin
      d.op_code      = lo8[2] ? OP_EI : OP_DI;
      d.operand_form = FORM_MASK;
      d.value        = {14'd0, lo8[1:0]};
    end else if (hi >= 8'h3C && hi <= 8'h3F) begin
      d.byte_regs = ~hi[0];
      d.value     = '0;
      if (hi[1]) begin
        d.op_code      = hi[0] ? OP_OUT : OP_OUTB;
        d.operand_form = FORM_IND_REG;
        d.first_reg    = mid4;
        d.second_reg   = lo4;
      end else begin
        d.op_code      = hi[0] ? OP_IN : OP_INB;
        d.operand_form = FORM_REG_IND;
        d.first_reg    = lo4;
        d.second_reg   = mid4;
      end
    end else if ((hi == 8'h3A || hi == 8'h3B) && (lo4 == 4'h4 || lo4 == 4'h6)) begin
      d.byte_regs    = ~hi[0];
      d.value        = ext_word_i;
      d.length_words = 2'd2;
      if (lo4[1]) begin
        d.op_code      = hi[0] ? OP_OUT : OP_OUTB;
        d.operand_form = FORM_PORT_REG;
        d.second_reg   = mid4;
      end else begin
        d.op_code      = hi[0] ? OP_IN : OP_INB;
        d.operand_form = FORM_REG_PORT;
        d.first_reg    = mid4;
      end
    end else if (instr_word_i == NOP_WORD) begin
      d.op_code      = OP_NOP;
      d.operand_form = FORM_NONE;
      d.value        = '0;
    end else if (instr_word_i == HALT_WORD) begin
      d.op_code      = OP_HALT;
      d.operand_form = FORM_NONE;
      d.value        = '0;
    end else if (instr_word_i == IRET_WORD) begin
      d.op_code      = OP_IRET;
      d.operand_form = FORM_NONE;
      d.value        = '0;
    end
    // Condition: always is carried in the code but not shown
    d.cond_code  = cc_used ? cc_raw : 4'h0;
    d.cond_shown = cc_used && (cc_raw != CC_ALWAYS);
  end

  assign dec_o = d;

endmodule

[rtl/ipd_out_reg.sv]
// ----------------------------------------------------------------------------
// ipd_out_reg
// Result register with stream handshake; packs the decode into tdata.
// ----------------------------------------------------------------------------
module ipd_out_reg
  import ipd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  dec_t                   dec_i,
  output logic                   ready_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic valid_q;
  logic valid_d;
  dec_t dec_q;

  // Register is free when empty or being drained this cycle
  assign ready_o = ~valid_q | m_axis_tready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dec_q <= dec_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {7'd0, dec_q.length_words, dec_q.value, dec_q.cond_code,
                            dec_q.cond_shown, dec_q.byte_regs, dec_q.second_reg,
                            dec_q.first_reg, dec_q.operand_form, dec_q.op_code};

endmodule

[rtl/instruction_predecoder_core.sv]
// ----------------------------------------------------------------------------
// instruction_predecoder_core
// Instruction predecoder: structured decode of one instruction word pair.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes the instruction address, the instruction word and the
//   following word in one transaction. Master stream gives one decode per
//   input transaction, in order.
//   From input acceptance to m_axis_tvalid_o the path is one input
//   register, then the decode logic, then the result register.
//   Throughput is one transaction per cycle while the receiver does not stall;
//   the decode is stateless and short enough to sit between the two registers.
//   When the receiver stalls, the result register holds its transaction and
//   the input register still accepts one more; after that s_axis_tready_o
//   drops until the master side drains.
//   Reset empties both registers; no transaction is pending afterwards and
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module instruction_predecoder_core
  import ipd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // [15:0] instr_addr, [31:16] instr_word, [47:32] ext_word
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [4:0] op_code, [8:5] operand_form, [12:9] first_reg, [16:13] second_reg,
  // [17] byte_regs, [18] cond_shown, [22:19] cond_code, [38:23] value,
  // [40:39] length_words, [47:41] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i
);

  logic        in_valid_q;
  logic        in_valid_d;
  logic [15:0] addr_q;
  logic [15:0] word_q;
  logic [15:0] ext_q;
  logic        out_ready;
  dec_t        dec;

  // Input register
  assign s_axis_tready_o = ~in_valid_q | out_ready;
  assign in_valid_d      = s_axis_tready_o ? s_axis_tvalid_i : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      addr_q <= s_axis_tdata_i[15:0];
      word_q <= s_axis_tdata_i[31:16];
      ext_q  <= s_axis_tdata_i[47:32];
    end
  end

  // Decode
  ipd_decode u_decode (
    .instr_addr_i (addr_q),
    .instr_word_i (word_q),
    .ext_word_i   (ext_q),
    .dec_o        (dec)
  );

  // Result register
  ipd_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_valid_q),
    .dec_i           (dec),
    .ready_o         (out_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

[rtl/ipd_checker.sv]
// ----------------------------------------------------------------------------
// ipd_checker
// Port-level assertions for the instruction predecoder.
// ----------------------------------------------------------------------------
module ipd_checker
  import ipd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i
);

  // Stalled result transaction holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Length is one or two words
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[40:39] == 2'd1 || m_axis_tdata_o[40:39] == 2'd2))
    else $error("bad length");

  // A shown condition is never the always code
  a_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[18] |-> m_axis_tdata_o[22:19] != CC_ALWAYS)
    else $error("always condition shown");

  // A data word has the data form and one word
  a_dw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[4:0] == OP_DW |->
      m_axis_tdata_o[8:5] == FORM_DATA && m_axis_tdata_o[40:39] == 2'd1)
    else $error("data word decode inconsistent");

  // An accepted input with an open output path shows up after the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o ##1 !m_axis_tvalid_o
      |=> m_axis_tvalid_o)
    else $error("result missing");

endmodule

bind instruction_predecoder_core ipd_checker u_ipd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

[tb/tb_instruction_predecoder_core.sv]
// ----------------------------------------------------------------------------
// tb_instruction_predecoder_core
// Self-checking bench for the instruction predecoder: directed corner words
// plus template-driven random instruction words, with random source gaps and
// sink back-pressure. Every decode is checked field by field against an
// in-bench decoder, in order.
// ----------------------------------------------------------------------------
module tb_instruction_predecoder_core;
  import ipd_pkg::*;

  localparam int unsigned IDLE_LIMIT = 1000;  // cycles without any transaction
  localparam int unsigned DRAIN_CYC  = 8;     // pipeline is 2 deep

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;

  // Idling controls, changed by the test tasks
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;

  dec_t        pending_decodes[$];
  int unsigned fail_count   = 0;
  int unsigned instr_count  = 0;
  int unsigned decode_count = 0;
  logic [31:0] ops_seen     = '0;

  always #2 clk = ~clk;

  instruction_predecoder_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  // Expected decode of one instruction word pair
  function automatic dec_t decode_instr(input logic [15:0] addr, input logic [15:0] word,
                                        input logic [15:0] ext);
    dec_t       d;
    logic [7:0] hi;
    logic [3:0] lo4;
    logic [3:0] mid4;
    logic       w;
    logic       o;
    d = '0;
    d.length_words = 2'd1;
    hi   = word[15:8];
    lo4  = word[3:0];
    mid4 = word[7:4];
    if (hi >= 8'h80 && hi <= 8'h8B) begin
      // ALU register-register group, even codes are byte ops
      d.op_code = op_e'(hi[4:0]);
      d.operand_form = FORM_REG_REG;
      d.first_reg = lo4;
      d.second_reg = mid4;
      d.byte_regs = ~hi[0];
    end else if (hi == 8'hA0 || hi == 8'hA1) begin
      d.op_code = hi[0] ? OP_LD : OP_LDB;
      d.operand_form = FORM_REG_REG;
      d.first_reg = lo4;
      d.second_reg = mid4;
      d.byte_regs = ~hi[0];
    end else if (hi[7:4] == 4'hC) begin
      d.op_code = OP_LDB;
      d.operand_form = FORM_REG_IMM;
      d.first_reg = hi[3:0];
      d.byte_regs = 1'b1;
      d.value = {8'h00, word[7:0]};
    end else if (hi == 8'h21 && mid4 == 4'h0) begin
      d.op_code = OP_LD;
      d.operand_form = FORM_REG_IMM;
      d.first_reg = lo4;
      d.value = ext;
      d.length_words = 2'd2;
    end else if (hi[7:4] == 4'hE) begin
      // JR: signed byte displacement in words
      d.op_code = OP_JR;
      d.operand_form = FORM_TARGET;
      d.cond_code = hi[3:0];
      d.cond_shown = (hi[3:0] != CC_ALWAYS);
      d.value = addr + 16'd2 + {{7{word[7]}}, word[7:0], 1'b0};
    end else if (hi == 8'h20 || hi == 8'h21) begin
      d.op_code = (hi == 8'h20) ? OP_LDB : OP_LD;
      d.operand_form = FORM_REG_IND;
      d.first_reg = lo4;
      d.second_reg = mid4;
      d.byte_regs = (hi == 8'h20);
    end else if (hi == 8'h2E || hi == 8'h2F) begin
      d.op_code = (hi == 8'h2E) ? OP_LDB : OP_LD;
      d.operand_form = FORM_IND_REG;
      d.first_reg = mid4;
      d.second_reg = lo4;
      d.byte_regs = (hi == 8'h2E);
    end else if ((hi == 8'h70 || hi == 8'h71) && mid4 == 4'h0) begin
      d.op_code = (hi == 8'h70) ? OP_LDB : OP_LD;
      d.operand_form = FORM_REG_ADDR;
      d.first_reg = lo4;
      d.byte_regs = (hi == 8'h70);
      d.value = ext;
      d.length_words = 2'd2;
    end else if ((hi == 8'h78 || hi == 8'h79) && mid4 == 4'h0) begin
      // register is the second shown operand
      d.op_code = (hi == 8'h78) ? OP_LDB : OP_LD;
      d.operand_form = FORM_ADDR_REG;
      d.second_reg = lo4;
      d.byte_regs = (hi == 8'h78);
      d.value = ext;
      d.length_words = 2'd2;
    end else if (hi == 8'h13) begin
      d.op_code = OP_PUSH;
      d.operand_form = FORM_IND_REG;
      d.first_reg = mid4;
      d.second_reg = lo4;
    end else if (hi == 8'h17) begin
      d.op_code = OP_POP;
      d.operand_form = FORM_REG_IND;
      d.first_reg = lo4;
      d.second_reg = mid4;
    end else if (hi[7:4] == 4'hD) begin
      // CALR: 12-bit backward displacement in words
      d.op_code = OP_CALR;
      d.operand_form = FORM_TARGET;
      d.value = addr + 16'd2 - {3'b000, word[11:0], 1'b0};
    end else if (hi == 8'h5F) begin
      d.op_code = OP_CALL;
      if (word[7:0] == 8'h00) begin
        d.operand_form = FORM_TARGET;
        d.value = ext;
        d.length_words = 2'd2;
      end else begin
        d.operand_form = FORM_IND;
        d.first_reg = mid4;
      end
    end else if (hi == 8'h5E) begin
      d.op_code = OP_JP;
      d.operand_form = FORM_TARGET;
      d.cond_code = lo4;
      d.cond_shown = (lo4 != CC_ALWAYS);
      d.value = ext;
      d.length_words = 2'd2;
    end else if (hi == 8'h1E) begin
      d.op_code = OP_JP;
      d.operand_form = FORM_IND;
      d.first_reg = mid4;
      d.cond_code = lo4;
      d.cond_shown = (lo4 != CC_ALWAYS);
    end else if (hi == 8'h9E) begin
      d.op_code = OP_RET;
      d.operand_form = (lo4 == CC_ALWAYS) ? FORM_NONE : FORM_COND;
      d.cond_code = lo4;
      d.cond_shown = (lo4 != CC_ALWAYS);
    end else if (hi == 8'h7C && word[7:3] == 5'b00000) begin
      d.op_code = word[2] ? OP_EI : OP_DI;
      d.operand_form = FORM_MASK;
      d.value = {14'd0, word[1:0]};
    end else if (hi >= 8'h3C && hi <= 8'h3F) begin
      // indirect I/O: bit 0 word, bit 1 output
      w = hi[0];
      o = hi[1];
      d.op_code = o ? (w ? OP_OUT : OP_OUTB) : (w ? OP_IN : OP_INB);
      d.operand_form = o ? FORM_IND_REG : FORM_REG_IND;
      d.first_reg = o ? mid4 : lo4;
      d.second_reg = o ? lo4 : mid4;
      d.byte_regs = ~w;
    end else if ((hi == 8'h3A || hi == 8'h3B) && (lo4 == 4'h4 || lo4 == 4'h6)) begin
      // direct port I/O
      w = hi[0];
      o = (lo4 == 4'h6);
      d.op_code = o ? (w ? OP_OUT : OP_OUTB) : (w ? OP_IN : OP_INB);
      d.operand_form = o ? FORM_PORT_REG : FORM_REG_PORT;
      d.first_reg = o ? 4'h0 : mid4;
      d.second_reg = o ? mid4 : 4'h0;
      d.byte_regs = ~w;
      d.value = ext;
      d.length_words = 2'd2;
    end else if (word == NOP_WORD) begin
      d.op_code = OP_NOP;
      d.operand_form = FORM_NONE;
    end else if (word == HALT_WORD) begin
      d.op_code = OP_HALT;
      d.operand_form = FORM_NONE;
    end else if (word == IRET_WORD) begin
      d.op_code = OP_IRET;
      d.operand_form = FORM_NONE;
    end else begin
      d.op_code = OP_DW;
      d.operand_form = FORM_DATA;
      d.value = word;
    end
    return d;
  endfunction

  // Random instruction word, mostly well-formed encodings of each group
  function automatic logic [15:0] random_instr_word();
    logic [15:0] rnd;
    rnd = 16'($urandom);
    case ($urandom_range(0, 23))
      0:  return {8'h80 + 8'($urandom_range(0, 11)), rnd[7:0]};
      1:  return {7'b1010000, rnd[8:0]};
      2:  return {4'hC, rnd[11:0]};
      3:  return {8'h21, 4'h0, rnd[3:0]};
      4:  return {4'hE, rnd[11:0]};
      5:  return {7'b0010000, rnd[8:0]};
      6:  return {7'b0010111, rnd[8:0]};
      7:  return {7'b0111000, rnd[8], 4'h0, rnd[3:0]};
      8:  return {7'b0111100, rnd[8], 4'h0, rnd[3:0]};
      9:  return {8'h13, rnd[7:0]};
      10: return {8'h17, rnd[7:0]};
      11: return {4'hD, rnd[11:0]};
      12: return {8'h5F, rnd[15] ? 8'h00 : rnd[7:0]};
      13: return {8'h5E, rnd[7:0]};
      14: return {8'h1E, rnd[7:0]};
      15: return {8'h9E, rnd[7:0]};
      16: return {8'h7C, 5'b00000, rnd[2:0]};
      17: return {6'b001111, rnd[9:0]};
      18: return {7'b0011101, rnd[8], rnd[7:4], rnd[14] ? 4'h6 : 4'h4};
      19: begin
        case (rnd[1:0])
          2'd0:    return NOP_WORD;
          2'd1:    return HALT_WORD;
          default: return IRET_WORD;
        endcase
      end
      default: return rnd;
    endcase
  endfunction

  // Address or extension word, biased toward the wrap points
  function automatic logic [15:0] random_word16();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'hFFFE;
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one instruction on the slave stream and wait for its transaction
  task automatic send_instr(input logic [15:0] addr, input logic [15:0] word,
                            input logic [15:0] ext);
    int unsigned gap;
    gap = src_idle_en ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {ext, word, addr};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_instr(random_word16(), random_instr_word(), random_word16());
  endtask

  task automatic report_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
    if (exp_val != act_val) begin
      fail_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  // Sink side: random stall drawn for every result
  initial begin
    int unsigned stall;
    forever begin
      stall = snk_idle_en ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // Scoreboard: record expected decodes at input, compare at output
  always @(posedge clk) begin
    dec_t exp_dec;
    if (rst_n) begin
      if (s_tvalid && s_tready) begin
        pending_decodes.push_back(decode_instr(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]));
        instr_count++;
      end
      if (m_tvalid && m_tready) begin
        decode_count++;
        ops_seen[m_tdata[4:0]] = 1'b1;
        if (pending_decodes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected decode, expected none actual %0h", $time, m_tdata);
        end else begin
          exp_dec = pending_decodes.pop_front();
          report_field("op_code",      exp_dec.op_code,      m_tdata[4:0]);
          report_field("operand_form", exp_dec.operand_form, m_tdata[8:5]);
          report_field("first_reg",    exp_dec.first_reg,    m_tdata[12:9]);
          report_field("second_reg",   exp_dec.second_reg,   m_tdata[16:13]);
          report_field("byte_regs",    exp_dec.byte_regs,    m_tdata[17]);
          report_field("cond_shown",   exp_dec.cond_shown,   m_tdata[18]);
          report_field("cond_code",    exp_dec.cond_code,    m_tdata[22:19]);
          report_field("value",        exp_dec.value,        m_tdata[38:23]);
          report_field("length_words", exp_dec.length_words, m_tdata[40:39]);
          report_field("padding",      0,                    m_tdata[47:41]);
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, %0d decodes still pending", $time, pending_decodes.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Corner encodings: all groups but PUSH, POP and LD @Rd, register and
  // displacement extremes, address wrap, always condition, near-miss data words
  task automatic test_directed();
    logic [47:0] vec[$];
    vec = '{
      {16'h0000, 16'h0000, 16'h0000}, {16'hFFFF, 16'hFFFF, 16'hFFFF},
      {16'h0000, 16'h8BFF, 16'h1234}, {16'h0000, 16'hA1F0, 16'h0000},
      {16'h0000, 16'hC5FF, 16'h0000}, {16'hFFFF, 16'h2103, 16'hFFFF},
      {16'h0000, 16'h2113, 16'h0000}, {16'h0000, 16'hE87F, 16'hFFFE},
      {16'h0000, 16'hE180, 16'h0000}, {16'h0000, 16'hDFFF, 16'h0000},
      {16'hABCD, 16'h5F00, 16'h2000}, {16'h0000, 16'h5FF1, 16'h2000},
      {16'h8000, 16'h5E08, 16'h4000}, {16'h0000, 16'h1EF3, 16'h4000},
      {16'h0000, 16'h9E08, 16'h0000}, {16'h0000, 16'h9E0F, 16'h0000},
      {16'h0000, 16'h7C07, 16'h0000}, {16'h0000, 16'h7C00, 16'h0000},
      {16'h0000, 16'h3DF1, 16'h0000}, {16'h00FF, 16'h3A54, 16'h0000},
      {16'h5555, 16'h3BA6, 16'h0000}, {16'h0000, NOP_WORD, 16'h0000},
      {16'h0000, HALT_WORD, 16'h0000}, {16'h0000, IRET_WORD, 16'h0000},
      {16'hAAAA, 16'h7809, 16'h0000}, {16'h0000, 16'h7010, 16'h0000},
      {16'h0000, 16'h7C08, 16'h0000}
    };
    foreach (vec[i]) send_instr(vec[i][15:0], vec[i][31:16], vec[i][47:32]);
  endtask

  // Random gaps on both sides
  task automatic test_random_traffic();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    send_random(250);
  endtask

  // Full-rate source against a stalling sink fills the pipeline
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b1;
    send_random(100);
  endtask

  // No idling on either side: one transaction per cycle
  task automatic test_streaming();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    send_random(100);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic();
    test_backpressure();
    test_streaming();
    s_tvalid <= 1'b0;
    wait (pending_decodes.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("Decoded %0d instructions, %0d results checked, %0d operation codes seen",
             instr_count, decode_count, $countones(ops_seen));
    $display("Traffic mixed random gaps, sink back-pressure and full-rate streaming");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
